### design/lns_pkg.sv
package lns_pkg;

    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int V_W        = 32;
    localparam int NOISE_W    = 16;
    localparam int TSTEP_W    = 32;
    localparam int REFR_W     = 16;
    localparam int SPK_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_NEURON_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_V      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REFRACT      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIAS         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_NOISE_GAIN   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECAY        = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_COEFF  = 3'd7;

    localparam logic [CNT_W-1:0] NEURON_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic [CNT_W-1:0]  neuron_count;
        logic [V_W-1:0]    threshold_voltage;
        logic [V_W-1:0]    reset_voltage;
        logic [REFR_W-1:0] refract_steps;
        logic [V_W-1:0]    bias_current;
        logic [V_W-1:0]    noise_gain;
        logic [V_W-1:0]    decay_coeff;
        logic [V_W-1:0]    input_coeff;
    } t_cfg;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_FIRE,
        MODE_INTEG
    } t_mode;

endpackage

### design/lif_neuron_step_unit.sv
// Leaky integrate-and-fire neuron array, advanced one neuron per stream word.
// Each input word names a neuron; the unit reads its state, applies a
// refractory countdown, a spike or a Q16.16 leak/integrate update, writes the
// state back for an in-range neuron and returns one result word. The datapath
// is a five-register pipeline (state read and multiplies, current sum, input
// multiply, voltage and write back, output register) and takes one word per
// clock while the output is not stalled. A word whose neuron is still in
// flight waits until that neuron's write back is done, so a new step of one
// neuron starts only after the last one is through. After reset a sweep
// clears the neuron state memory, one entry per cycle; no word is taken during
// the sweep, configuration writes are. Configure only while idle.
module lif_neuron_step_unit #(
    parameter int NEURONS    = 1024,
    parameter int MAX_SPIKES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lns_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [lns_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // neuron_index, synaptic_input, noise_sample, time_step, zero pad
    input  logic [lns_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_index, new_voltage, spike_total, zero pad
    output logic [lns_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // in_range, fired
    output logic [lns_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int HW = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
    localparam int SW = 64 + HW;
    localparam int TW = (NEURONS * MAX_SPIKES > 1) ? $clog2(NEURONS * MAX_SPIKES) : 1;

    lns_pkg::t_cfg cfg;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          pipe_ready, rd_en, wr_en, spk_we;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [SW-1:0] rd_state, wr_state;
    logic [TW-1:0] spk_addr;
    logic [31:0]   spk_data;
    logic [9:0]    out_idx;
    logic          out_inr, out_fired;
    logic [31:0]   out_volt;
    logic [15:0]   out_spk;

    lns_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (32'(r_clr_addr) == NEURONS - 1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    lns_pipe #(
        .NEURONS    (NEURONS),
        .MAX_SPIKES (MAX_SPIKES)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid && !r_clr_busy),
        .o_in_ready  (pipe_ready),
        .i_in_idx    (s_axis_tdata[9:0]),
        .i_in_syn    (s_axis_tdata[41:10]),
        .i_in_noise  (s_axis_tdata[57:42]),
        .i_in_tstep  (s_axis_tdata[89:58]),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_state  (rd_state),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_state  (wr_state),
        .o_spk_we    (spk_we),
        .o_spk_addr  (spk_addr),
        .o_spk_data  (spk_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_idx   (out_idx),
        .o_out_inr   (out_inr),
        .o_out_fired (out_fired),
        .o_out_volt  (out_volt),
        .o_out_spk   (out_spk)
    );

    lns_ram #(
        .WIDTH (SW),
        .DEPTH (NEURONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_clr_busy || wr_en),
        .i_waddr (r_clr_busy ? r_clr_addr : wr_addr),
        .i_wdata (r_clr_busy ? '0 : wr_state),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_state)
    );

    // spike-time rings, write only from this side
    lns_ram #(
        .WIDTH (32),
        .DEPTH (NEURONS * MAX_SPIKES)
    ) u_spike_ram (
        .i_clk   (i_clk),
        .i_we    (spk_we),
        .i_waddr (spk_addr),
        .i_wdata (spk_data),
        .i_re    (1'b0),
        .i_raddr ('0),
        .o_rdata ()
    );

    assign s_axis_tready = pipe_ready && !r_clr_busy;
    assign m_axis_tdata  = {6'd0, out_spk, out_volt, out_idx};
    assign m_axis_tuser  = {out_fired, out_inr};
endmodule

### design/lns_ram.sv
module lns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/lns_cfg.sv
module lns_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [lns_pkg::CFG_ADDR_W-1:0]    i_addr,
    input  logic [lns_pkg::CFG_DATA_W-1:0]    i_wdata,
    output lns_pkg::t_cfg                     o_cfg
);
    lns_pkg::t_cfg r_cfg;
    lns_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_addr)
                lns_pkg::CFG_NEURON_COUNT: n_cfg.neuron_count = i_wdata[lns_pkg::CNT_W-1:0];
                lns_pkg::CFG_THRESHOLD:    n_cfg.threshold_voltage = i_wdata;
                lns_pkg::CFG_RESET_V:      n_cfg.reset_voltage = i_wdata;
                lns_pkg::CFG_REFRACT:      n_cfg.refract_steps = i_wdata[lns_pkg::REFR_W-1:0];
                lns_pkg::CFG_BIAS:         n_cfg.bias_current = i_wdata;
                lns_pkg::CFG_NOISE_GAIN:   n_cfg.noise_gain = i_wdata;
                lns_pkg::CFG_DECAY:        n_cfg.decay_coeff = i_wdata;
                lns_pkg::CFG_INPUT_COEFF:  n_cfg.input_coeff = i_wdata;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_cfg.neuron_count <= lns_pkg::NEURON_COUNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

### design/lns_pipe.sv
module lns_pipe #(
    parameter int NEURONS    = 1024,
    parameter int MAX_SPIKES = 16,
    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1,
    localparam int HW = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1,
    localparam int SW = 64 + HW,
    localparam int TW = (NEURONS * MAX_SPIKES > 1) ? $clog2(NEURONS * MAX_SPIKES) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lns_pkg::t_cfg                     i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lns_pkg::IDX_W-1:0]         i_in_idx,
    input  logic [lns_pkg::V_W-1:0]           i_in_syn,
    input  logic [lns_pkg::NOISE_W-1:0]       i_in_noise,
    input  logic [lns_pkg::TSTEP_W-1:0]       i_in_tstep,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  logic [SW-1:0]                     i_rd_state,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [SW-1:0]                     o_wr_state,
    output logic                              o_spk_we,
    output logic [TW-1:0]                     o_spk_addr,
    output logic [lns_pkg::TSTEP_W-1:0]       o_spk_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lns_pkg::IDX_W-1:0]         o_out_idx,
    output logic                              o_out_inr,
    output logic                              o_out_fired,
    output logic [lns_pkg::V_W-1:0]           o_out_volt,
    output logic [lns_pkg::SPK_W-1:0]         o_out_spk
);
    localparam int IW = lns_pkg::IDX_W;

    // state word: membrane | refractory << 32 | count << 48 | head << 64

    // stage A: state read back, multiplies
    logic                        r_a_valid, r_a_inr;
    logic [IW-1:0]               r_a_idx;
    logic [31:0]                 r_a_syn, r_a_tstep;
    logic [15:0]                 r_a_noise;
    // stage B: current sum
    logic                        r_b_valid, r_b_inr;
    logic [IW-1:0]               r_b_idx;
    lns_pkg::t_mode              r_b_mode;
    logic [31:0]                 r_b_v, r_b_syn, r_b_tstep;
    logic [15:0]                 r_b_refr, r_b_cnt;
    logic [HW-1:0]               r_b_head;
    logic signed [47:0]          r_b_prod_n;
    logic signed [63:0]          r_b_prod_d;
    // stage C: input multiply
    logic                        r_c_valid, r_c_inr;
    logic [IW-1:0]               r_c_idx;
    lns_pkg::t_mode              r_c_mode;
    logic [31:0]                 r_c_v, r_c_tstep, r_c_isum;
    logic [15:0]                 r_c_refr, r_c_cnt;
    logic [HW-1:0]               r_c_head;
    logic signed [63:0]          r_c_prod_d;
    // stage D: voltage, state update, write back
    logic                        r_d_valid, r_d_inr;
    logic [IW-1:0]               r_d_idx;
    lns_pkg::t_mode              r_d_mode;
    logic [31:0]                 r_d_v, r_d_tstep;
    logic [15:0]                 r_d_refr, r_d_cnt;
    logic [HW-1:0]               r_d_head;
    logic signed [63:0]          r_d_prod_d, r_d_prod_b;
    // output register
    logic                        r_o_valid, r_o_inr, r_o_fired;
    logic [IW-1:0]               r_o_idx;
    logic [31:0]                 r_o_volt;
    logic [15:0]                 r_o_spk;

    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
    logic accept, hazard, in_range;

    assign rdy_e = !r_o_valid || i_out_ready;
    assign rdy_d = !r_d_valid || rdy_e;
    assign rdy_c = !r_c_valid || rdy_d;
    assign rdy_b = !r_b_valid || rdy_c;
    assign rdy_a = !r_a_valid || rdy_b;

    // same neuron still in flight: wait until its write back is done
    assign hazard = (r_a_valid && r_a_idx == i_in_idx) || (r_b_valid && r_b_idx == i_in_idx)
                 || (r_c_valid && r_c_idx == i_in_idx) || (r_d_valid && r_d_idx == i_in_idx);

    assign o_in_ready = rdy_a && !hazard;
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = ({1'b0, i_in_idx} < i_cfg.neuron_count) && (32'(i_in_idx) < NEURONS);
    assign o_rd_en    = accept;
    assign o_rd_addr  = AW'(i_in_idx);

    // stage A logic
    logic [31:0]        a_v;
    logic [15:0]        a_refr, a_cnt;
    logic [HW-1:0]      a_head;
    lns_pkg::t_mode     a_mode;
    logic signed [47:0] a_prod_n;
    logic signed [63:0] a_prod_d;

    assign a_v    = i_rd_state[31:0];
    assign a_refr = i_rd_state[47:32];
    assign a_cnt  = i_rd_state[63:48];
    assign a_head = i_rd_state[SW-1:64];

    always_comb begin
        if (a_refr != 16'd0) begin
            a_mode = lns_pkg::MODE_HOLD;
        end else if ($signed(a_v) >= $signed(i_cfg.threshold_voltage)) begin
            a_mode = lns_pkg::MODE_FIRE;
        end else begin
            a_mode = lns_pkg::MODE_INTEG;
        end
    end

    assign a_prod_n = $signed(r_a_noise) * $signed(i_cfg.noise_gain);
    assign a_prod_d = $signed(a_v) * $signed(i_cfg.decay_coeff);

    // stage B logic
    logic signed [47:0] b_cur;
    logic [31:0]        b_isum;

    assign b_cur = $signed(48'($signed(r_b_syn))) + $signed(48'($signed(i_cfg.bias_current)))
                 + (r_b_prod_n >>> 12);
    assign b_isum = ((&b_cur[47:31]) || !(|b_cur[47:31])) ? b_cur[31:0]
                  : (b_cur[47] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // stage C logic
    logic signed [63:0] c_prod_b;

    assign c_prod_b = $signed(r_c_isum) * $signed(i_cfg.input_coeff);

    // stage D logic
    logic signed [64:0] d_sum, d_tot;
    logic [31:0]        d_vsat, d_v_new;
    logic [15:0]        d_refr_new, d_cnt_new;
    logic [HW-1:0]      d_head_new;
    logic               d_fire;

    assign d_sum  = $signed(65'(r_d_prod_d)) + $signed(65'(r_d_prod_b));
    assign d_tot  = d_sum >>> 16;
    assign d_vsat = ((&d_tot[64:31]) || !(|d_tot[64:31])) ? d_tot[31:0]
                  : (d_tot[64] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign d_fire = (r_d_mode == lns_pkg::MODE_FIRE);

    always_comb begin
        d_v_new    = r_d_v;
        d_refr_new = r_d_refr;
        d_cnt_new  = r_d_cnt;
        d_head_new = r_d_head;
        case (r_d_mode)
            lns_pkg::MODE_HOLD: begin
                d_refr_new = r_d_refr - 16'd1;
            end
            lns_pkg::MODE_FIRE: begin
                d_v_new    = i_cfg.reset_voltage;
                d_refr_new = i_cfg.refract_steps;
                d_cnt_new  = (r_d_cnt == 16'hFFFF) ? r_d_cnt : r_d_cnt + 16'd1;
                d_head_new = (32'(r_d_head) == MAX_SPIKES - 1) ? '0 : r_d_head + HW'(1);
            end
            lns_pkg::MODE_INTEG: begin
                d_v_new = d_vsat;
            end
            default: begin
                d_v_new = r_d_v;
            end
        endcase
    end

    assign o_wr_en    = r_d_valid && rdy_e && r_d_inr;
    assign o_wr_addr  = AW'(r_d_idx);
    assign o_wr_state = {d_head_new, d_cnt_new, d_refr_new, d_v_new};
    assign o_spk_we   = o_wr_en && d_fire;
    assign o_spk_addr = TW'(TW'(r_d_idx) * TW'(MAX_SPIKES)) + TW'(r_d_head);
    assign o_spk_data = r_d_tstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (rdy_a) r_a_valid <= accept;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
            if (rdy_d) r_d_valid <= r_c_valid;
            if (rdy_e) r_o_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_idx   <= i_in_idx;
            r_a_inr   <= in_range;
            r_a_syn   <= i_in_syn;
            r_a_noise <= i_in_noise;
            r_a_tstep <= i_in_tstep;
        end
        if (rdy_b && r_a_valid) begin
            r_b_idx    <= r_a_idx;
            r_b_inr    <= r_a_inr;
            r_b_mode   <= a_mode;
            r_b_v      <= a_v;
            r_b_refr   <= a_refr;
            r_b_cnt    <= a_cnt;
            r_b_head   <= a_head;
            r_b_syn    <= r_a_syn;
            r_b_tstep  <= r_a_tstep;
            r_b_prod_n <= a_prod_n;
            r_b_prod_d <= a_prod_d;
        end
        if (rdy_c && r_b_valid) begin
            r_c_idx    <= r_b_idx;
            r_c_inr    <= r_b_inr;
            r_c_mode   <= r_b_mode;
            r_c_v      <= r_b_v;
            r_c_refr   <= r_b_refr;
            r_c_cnt    <= r_b_cnt;
            r_c_head   <= r_b_head;
            r_c_tstep  <= r_b_tstep;
            r_c_isum   <= b_isum;
            r_c_prod_d <= r_b_prod_d;
        end
        if (rdy_d && r_c_valid) begin
            r_d_idx    <= r_c_idx;
            r_d_inr    <= r_c_inr;
            r_d_mode   <= r_c_mode;
            r_d_v      <= r_c_v;
            r_d_refr   <= r_c_refr;
            r_d_cnt    <= r_c_cnt;
            r_d_head   <= r_c_head;
            r_d_tstep  <= r_c_tstep;
            r_d_prod_d <= r_c_prod_d;
            r_d_prod_b <= c_prod_b;
        end
        if (rdy_e && r_d_valid) begin
            r_o_idx   <= r_d_idx;
            r_o_inr   <= r_d_inr;
            r_o_fired <= r_d_inr && d_fire;
            r_o_volt  <= r_d_inr ? d_v_new : 32'd0;
            r_o_spk   <= r_d_inr ? d_cnt_new : 16'd0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_idx   = r_o_idx;
    assign o_out_inr   = r_o_inr;
    assign o_out_fired = r_o_fired;
    assign o_out_volt  = r_o_volt;
    assign o_out_spk   = r_o_spk;
endmodule
